/* hdl/pcbs_pkg.sv */
// Shared types and constants for the per-class box suppression block.
`timescale 1ns / 1ps
package pcbs_pkg;

  localparam int MAX_BOXES_DEF = 64;
  localparam logic [15:0] THR_RESET = 16'd29491;
  // Wait cycles between the last scan cycle and the decision.
  // They cover the four register stages of the overlap unit.
  localparam int OVL_DRAIN = 3;

  typedef struct packed {
    logic [15:0] box_left;
    logic [15:0] box_top;
    logic [15:0] box_width;
    logic [15:0] box_height;
    logic [15:0] score;
    logic [7:0]  class_id;
    logic        frame_end;
  } pcbs_in_t;

  typedef struct packed {
    logic [15:0] out_left;
    logic [15:0] out_top;
    logic [15:0] out_width;
    logic [15:0] out_height;
    logic [15:0] out_score;
    logic [7:0]  out_class;
    logic        last_kept;
    logic        dropped_some;
  } pcbs_out_t;

  // One stored box as held in a cell.
  typedef struct packed {
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] width;
    logic [15:0] height;
    logic [15:0] score;
    logic [7:0]  class_id;
  } pcbs_entry_t;

  // Control for the cells of the ranking chain.
  typedef struct packed {
    logic ins;
    logic pop;
  } pcbs_sort_ctrl_t;

  // Control for the cells of the kept-box chain.
  typedef struct packed {
    logic rot;
    logic app;
    logic shl;
  } pcbs_kept_ctrl_t;

endpackage

/* hdl/pcbs_sort_cell.sv */
// One cell of the ranking chain: holds a box, takes part in sorted insert and pop.
`timescale 1ns / 1ps
module pcbs_sort_cell
  import pcbs_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  pcbs_sort_ctrl_t ctrl,
  input  pcbs_entry_t     new_entry,
  input  pcbs_entry_t     prev_entry,
  input  logic            prev_valid,
  input  logic            prev_lt,
  input  pcbs_entry_t     next_entry,
  input  logic            next_valid,
  output pcbs_entry_t     entry,
  output logic            valid,
  output logic            lt
);

  pcbs_entry_t entry_r;
  logic        valid_r;

  // An empty cell or a lower score yields its place to the new box; ties stay ahead.
  assign lt    = !valid_r || (entry_r.score < new_entry.score);
  assign entry = entry_r;
  assign valid = valid_r;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctrl.pop) begin
      valid_r <= next_valid;
    end else if (ctrl.ins && lt) begin
      valid_r <= prev_lt ? prev_valid : 1'b1;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      entry_r <= next_entry;
    end else if (ctrl.ins && lt) begin
      entry_r <= prev_lt ? prev_entry : new_entry;
    end
  end

endmodule

/* hdl/pcbs_kept_cell.sv */
// One cell of the kept-box chain: rotates past the overlap unit, appends, shifts out.
`timescale 1ns / 1ps
module pcbs_kept_cell
  import pcbs_pkg::*;
(
  input  logic            clk,
  input  pcbs_kept_ctrl_t ctrl,
  input  logic            is_tail,
  input  logic            is_app,
  input  pcbs_entry_t     head_entry,
  input  pcbs_entry_t     next_entry,
  input  pcbs_entry_t     cand,
  output pcbs_entry_t     entry
);

  pcbs_entry_t entry_r;

  assign entry = entry_r;

  // The tail of the occupied part takes the head during a rotation.
  always_ff @(posedge clk) begin
    if (ctrl.rot) begin
      entry_r <= is_tail ? head_entry : next_entry;
    end else if (ctrl.app && is_app) begin
      entry_r <= cand;
    end else if (ctrl.shl) begin
      entry_r <= next_entry;
    end
  end

endmodule

/* hdl/pcbs_overlap.sv */
// Pipelined overlap test: intersection * 65536 > threshold * union.
`timescale 1ns / 1ps
module pcbs_overlap
  import pcbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  pcbs_entry_t box_a,
  input  pcbs_entry_t box_b,
  input  logic [15:0] thr,
  output logic        hit
);

  logic [16:0] ar, br, ab, bb, x1, x2, y1, y2, iw, ih;
  logic        s1_v_r, s2_v_r, s3_v_r, hit_r;
  logic [16:0] s1_iw_r, s1_ih_r;
  logic [31:0] s1_aa_r, s1_ba_r;
  logic [33:0] s2_inter_r, s3_inter_r;
  logic [32:0] s2_asum_r, uni;
  logic [48:0] s3_rhs_r;

  // Stage one: clipped extents and both areas.
  always_comb begin
    ar = {1'b0, box_a.left} + {1'b0, box_a.width};
    br = {1'b0, box_b.left} + {1'b0, box_b.width};
    ab = {1'b0, box_a.top} + {1'b0, box_a.height};
    bb = {1'b0, box_b.top} + {1'b0, box_b.height};
    x1 = (box_a.left > box_b.left) ? {1'b0, box_a.left} : {1'b0, box_b.left};
    y1 = (box_a.top > box_b.top) ? {1'b0, box_a.top} : {1'b0, box_b.top};
    x2 = (ar < br) ? ar : br;
    y2 = (ab < bb) ? ab : bb;
    iw = (x2 > x1) ? x2 - x1 : 17'd0;
    ih = (y2 > y1) ? y2 - y1 : 17'd0;
  end

  // Stage three union; it never goes below the intersection.
  assign uni = s2_asum_r - {1'b0, s2_inter_r[31:0]} - {s2_inter_r[33:32], 31'd0};

  always_ff @(posedge clk) begin
    s1_iw_r    <= iw;
    s1_ih_r    <= ih;
    s1_aa_r    <= box_a.width * box_a.height;
    s1_ba_r    <= box_b.width * box_b.height;
    s2_inter_r <= s1_iw_r * s1_ih_r;
    s2_asum_r  <= {1'b0, s1_aa_r} + {1'b0, s1_ba_r};
    s3_inter_r <= s2_inter_r;
    s3_rhs_r   <= thr * uni;
  end

  // Valid tags and the final compare; a zero intersection never suppresses.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      hit_r  <= 1'b0;
    end else begin
      s1_v_r <= in_vld;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      hit_r  <= s3_v_r && (s3_inter_r != 34'd0) &&
                ({s3_inter_r, 16'd0} > {1'b0, s3_rhs_r});
    end
  end

  assign hit = hit_r;

endmodule

/* hdl/per_class_box_suppression_core.sv */
// Top level of the per-class greedy box suppression block.
// Usage: a frame of boxes arrives on the in_ channel, one request per box,
// the last one flagged by frame_end. Requests are accepted when in_valid is
// high and in_stall low; each box is inserted into a ranking chain of cells
// as it is accepted, so collection runs at one box per cycle. Boxes beyond
// MAX_BOXES are discarded and dropped_some is set on every result of that frame.
// After frame_end, in_stall stays high while boxes are popped in score order
// (ties in arrival order) and each is checked against every kept box of the
// same class by a four-stage overlap pipeline fed from a rotating chain of
// kept cells: each candidate is popped, the kept boxes rotate once past the
// pipeline, the pipeline drains and the candidate is then appended or
// dropped; scan and drain are skipped when no box is kept yet.
// Kept boxes then leave on the out_ channel through an output register, one
// per cycle when out_stall is low, with last_kept on the final one; a stall
// holds the register and the chain. Collection of the next frame starts once
// the last result is loaded. Synchronous active-low reset empties all chains
// and restores the threshold to its default; cfg_we writes the threshold.
`timescale 1ns / 1ps
module per_class_box_suppression_core
  import pcbs_pkg::*;
#(
  parameter int MAX_BOXES = MAX_BOXES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  pcbs_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output pcbs_out_t   out_data,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data
);

  localparam int CW = $clog2(MAX_BOXES + 1);
  localparam int DW = $clog2(OVL_DRAIN + 1);

  typedef enum logic [2:0] {
    ST_COLLECT, ST_PICK, ST_SCAN, ST_DRAIN, ST_DECIDE, ST_EMIT
  } state_t;

  state_t          state_r;
  logic [15:0]     thr_r;
  logic [CW-1:0]   cnt_r, kept_cnt_r, scan_r, emit_r;
  logic [DW-1:0]   drain_r;
  logic            ovf_r, frame_ovf_r, supp_r, out_valid_r;
  pcbs_out_t       out_data_r;
  pcbs_entry_t     cand_r, new_entry;
  pcbs_sort_ctrl_t sctl;
  pcbs_kept_ctrl_t kctl;
  logic            accept, full, hit, can_load;

  pcbs_entry_t s_ent [MAX_BOXES];
  logic        s_vld [MAX_BOXES];
  logic        s_lt  [MAX_BOXES];
  pcbs_entry_t k_ent [MAX_BOXES];

  assign in_stall  = (state_r != ST_COLLECT);
  assign accept    = in_valid && !in_stall;
  assign full      = (cnt_r == CW'(MAX_BOXES));
  assign can_load  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    new_entry.left     = in_data.box_left;
    new_entry.top      = in_data.box_top;
    new_entry.width    = in_data.box_width;
    new_entry.height   = in_data.box_height;
    new_entry.score    = in_data.score;
    new_entry.class_id = in_data.class_id;
  end

  // Chain controls.
  always_comb begin
    sctl.ins = accept && !full;
    sctl.pop = (state_r == ST_PICK) && (cnt_r != '0);
    kctl.rot = (state_r == ST_SCAN);
    kctl.app = (state_r == ST_DECIDE) && !(supp_r || hit);
    kctl.shl = (state_r == ST_EMIT) && can_load && (emit_r != '0);
  end

  // Ranking chain.
  for (genvar i = 0; i < MAX_BOXES; i++) begin : g_sort
    pcbs_entry_t pe, ne;
    logic        pv, pl, nv;
    if (i == 0) begin : g_first
      assign pe = new_entry;
      assign pv = 1'b0;
      assign pl = 1'b0;
    end else begin : g_mid
      assign pe = s_ent[i-1];
      assign pv = s_vld[i-1];
      assign pl = s_lt[i-1];
    end
    if (i == MAX_BOXES - 1) begin : g_last
      assign ne = new_entry;
      assign nv = 1'b0;
    end else begin : g_inner
      assign ne = s_ent[i+1];
      assign nv = s_vld[i+1];
    end
    pcbs_sort_cell u_cell (
      .clk(clk), .rst_n(rst_n), .ctrl(sctl), .new_entry(new_entry),
      .prev_entry(pe), .prev_valid(pv), .prev_lt(pl),
      .next_entry(ne), .next_valid(nv),
      .entry(s_ent[i]), .valid(s_vld[i]), .lt(s_lt[i])
    );
  end

  // Kept-box chain.
  for (genvar i = 0; i < MAX_BOXES; i++) begin : g_kept
    pcbs_entry_t ne;
    if (i == MAX_BOXES - 1) begin : g_last
      assign ne = k_ent[0];
    end else begin : g_inner
      assign ne = k_ent[i+1];
    end
    pcbs_kept_cell u_cell (
      .clk(clk), .ctrl(kctl),
      .is_tail(kept_cnt_r == CW'(i + 1)), .is_app(kept_cnt_r == CW'(i)),
      .head_entry(k_ent[0]), .next_entry(ne), .cand(cand_r), .entry(k_ent[i])
    );
  end

  // Overlap unit; only boxes of the same class are presented.
  pcbs_overlap u_ovl (
    .clk(clk), .rst_n(rst_n),
    .in_vld(kctl.rot && (k_ent[0].class_id == cand_r.class_id)),
    .box_a(k_ent[0]), .box_b(cand_r), .thr(thr_r), .hit(hit)
  );

  // Candidate register.
  always_ff @(posedge clk) begin
    if (sctl.pop) begin
      cand_r <= s_ent[0];
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (kctl.shl) begin
      out_data_r.out_left     <= k_ent[0].left;
      out_data_r.out_top      <= k_ent[0].top;
      out_data_r.out_width    <= k_ent[0].width;
      out_data_r.out_height   <= k_ent[0].height;
      out_data_r.out_score    <= k_ent[0].score;
      out_data_r.out_class    <= k_ent[0].class_id;
      out_data_r.last_kept    <= (emit_r == CW'(1));
      out_data_r.dropped_some <= frame_ovf_r;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_COLLECT;
      thr_r       <= THR_RESET;
      cnt_r       <= '0;
      kept_cnt_r  <= '0;
      scan_r      <= '0;
      emit_r      <= '0;
      drain_r     <= '0;
      ovf_r       <= 1'b0;
      frame_ovf_r <= 1'b0;
      supp_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        thr_r <= cfg_data;
      end
      if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (kctl.shl) begin
        out_valid_r <= 1'b1;
      end
      case (state_r)
        ST_COLLECT: begin
          if (accept) begin
            if (!full) begin
              cnt_r <= cnt_r + CW'(1);
            end else begin
              ovf_r <= 1'b1;
            end
            if (in_data.frame_end) begin
              frame_ovf_r <= ovf_r || full;
              state_r     <= ST_PICK;
            end
          end
        end
        ST_PICK: begin
          supp_r <= 1'b0;
          if (cnt_r == '0) begin
            emit_r  <= kept_cnt_r;
            state_r <= ST_EMIT;
          end else begin
            cnt_r  <= cnt_r - CW'(1);
            scan_r <= kept_cnt_r;
            state_r <= (kept_cnt_r == '0) ? ST_DECIDE : ST_SCAN;
          end
        end
        ST_SCAN: begin
          supp_r <= supp_r || hit;
          scan_r <= scan_r - CW'(1);
          if (scan_r == CW'(1)) begin
            drain_r <= DW'(OVL_DRAIN);
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          supp_r  <= supp_r || hit;
          drain_r <= drain_r - DW'(1);
          if (drain_r == DW'(1)) begin
            state_r <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (kctl.app) begin
            kept_cnt_r <= kept_cnt_r + CW'(1);
          end
          state_r <= ST_PICK;
        end
        ST_EMIT: begin
          if (kctl.shl) begin
            emit_r <= emit_r - CW'(1);
            if (emit_r == CW'(1)) begin
              kept_cnt_r <= '0;
              ovf_r      <= 1'b0;
              state_r    <= ST_COLLECT;
            end
          end
        end
        default: begin
          state_r <= ST_COLLECT;
        end
      endcase
    end
  end

endmodule

/* bench/per_class_box_suppression_core_tb.sv */
// Self-checking testbench for the per-class box suppression core.
`timescale 1ns / 1ps
module per_class_box_suppression_core_tb;
  import pcbs_pkg::*;

  localparam int CAPACITY = MAX_BOXES_DEF;
  localparam int TAIL_CYCLES = 200;
  localparam longint CYCLE_LIMIT = 3000000;

  // Idle phases: no idling, sender idle, receiver stalling, both.
  typedef enum int {PH_NONE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} idle_phase_e;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  pcbs_in_t in_data;
  logic out_valid;
  logic out_stall;
  pcbs_out_t out_data;
  logic cfg_we;
  logic [15:0] cfg_data;

  per_class_box_suppression_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // Pending box requests, expected kept boxes and predictor state.
  pcbs_in_t    pending_boxes[$];
  pcbs_out_t   expected_kept[$];
  pcbs_entry_t frame_boxes[$];
  logic        frame_overflow;
  logic [15:0] threshold;
  idle_phase_e idle_phase;
  int          error_count;
  int          boxes_sent;
  int          kept_seen;
  int          frames_sent;
  longint      cycle_count;

  // Start the clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string what);
    error_count++;
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
  endtask

  // True when the kept box overlaps the candidate too much.
  function automatic bit overlap_suppresses(pcbs_entry_t kept, pcbs_entry_t cand,
                                            logic [15:0] thr);
    logic [63:0] x1, y1, x2, y2, iw, ih, inter, union_area;
    x1 = (kept.left > cand.left) ? kept.left : cand.left;
    y1 = (kept.top > cand.top) ? kept.top : cand.top;
    x2 = ((64'(kept.left) + kept.width) < (64'(cand.left) + cand.width)) ?
         64'(kept.left) + kept.width : 64'(cand.left) + cand.width;
    y2 = ((64'(kept.top) + kept.height) < (64'(cand.top) + cand.height)) ?
         64'(kept.top) + kept.height : 64'(cand.top) + cand.height;
    iw = (x2 > x1) ? x2 - x1 : 64'd0;
    ih = (y2 > y1) ? y2 - y1 : 64'd0;
    inter = iw * ih;
    if (inter == 0) return 1'b0;
    union_area = 64'(kept.width) * kept.height + 64'(cand.width) * cand.height - inter;
    if (union_area == 0) return 1'b0;
    return (inter << 16) > 64'(thr) * union_area;
  endfunction

  // Store one accepted box; on frame end rank, suppress and queue the kept boxes.
  task automatic predict_box(input pcbs_in_t req);
    pcbs_entry_t ranked[$];
    pcbs_entry_t kept[$];
    pcbs_entry_t e;
    pcbs_out_t   res;
    int          pos;
    bit          keep;
    if (frame_boxes.size() < CAPACITY) begin
      e = '{req.box_left, req.box_top, req.box_width, req.box_height,
            req.score, req.class_id};
      frame_boxes.push_back(e);
    end else begin
      frame_overflow = 1'b1;
    end
    if (!req.frame_end) return;
    // Stable ranking by descending score.
    foreach (frame_boxes[i]) begin
      pos = ranked.size();
      while (pos > 0 && ranked[pos-1].score < frame_boxes[i].score) pos--;
      ranked.insert(pos, frame_boxes[i]);
    end
    foreach (ranked[i]) begin
      keep = 1'b1;
      foreach (kept[j]) begin
        if (kept[j].class_id == ranked[i].class_id &&
            overlap_suppresses(kept[j], ranked[i], threshold)) begin
          keep = 1'b0;
          break;
        end
      end
      if (keep) kept.push_back(ranked[i]);
    end
    foreach (kept[i]) begin
      res.out_left     = kept[i].left;
      res.out_top      = kept[i].top;
      res.out_width    = kept[i].width;
      res.out_height   = kept[i].height;
      res.out_score    = kept[i].score;
      res.out_class    = kept[i].class_id;
      res.last_kept    = (i == kept.size() - 1);
      res.dropped_some = frame_overflow;
      expected_kept.push_back(res);
    end
    frame_boxes.delete();
    frame_overflow = 1'b0;
  endtask

  // Driver: present pending boxes, idling at random in the sender phases.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (pending_boxes.size() > 0 &&
          !((idle_phase == PH_SEND_IDLE &&
             $urandom_range(99) < 76) ||
            (idle_phase == PH_BOTH &&
             $urandom_range(99) < 16))) begin
        in_valid <= 1'b1;
        in_data  <= pending_boxes.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall in the receiver phases.
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= (idle_phase == PH_RECV_STALL && $urandom_range(99) < 76) ||
                      (idle_phase == PH_BOTH && $urandom_range(99) < 16);
  end

  // Monitor: predict on accepted requests, compare accepted results.
  always @(posedge clk) begin
    cycle_count++;
    if (rst_n && in_valid && !in_stall) begin
      predict_box(in_data);
      boxes_sent++;
    end
    if (rst_n && out_valid && !out_stall) begin
      kept_seen++;
      if (expected_kept.size() == 0) begin
        report_mismatch("kept box with no expectation waiting");
      end else begin
        pcbs_out_t exp_res;
        exp_res = expected_kept.pop_front();
        if (out_data.out_left !== exp_res.out_left)
          report_mismatch($sformatf("out_left %0h exp %0h", out_data.out_left,
                                    exp_res.out_left));
        if (out_data.out_top !== exp_res.out_top)
          report_mismatch($sformatf("out_top %0h exp %0h", out_data.out_top,
                                    exp_res.out_top));
        if (out_data.out_width !== exp_res.out_width)
          report_mismatch($sformatf("out_width %0h exp %0h", out_data.out_width,
                                    exp_res.out_width));
        if (out_data.out_height !== exp_res.out_height)
          report_mismatch($sformatf("out_height %0h exp %0h", out_data.out_height,
                                    exp_res.out_height));
        if (out_data.out_score !== exp_res.out_score)
          report_mismatch($sformatf("out_score %0h exp %0h", out_data.out_score,
                                    exp_res.out_score));
        if (out_data.out_class !== exp_res.out_class)
          report_mismatch($sformatf("out_class %0h exp %0h", out_data.out_class,
                                    exp_res.out_class));
        if (out_data.last_kept !== exp_res.last_kept)
          report_mismatch($sformatf("last_kept %0b exp %0b", out_data.last_kept,
                                    exp_res.last_kept));
        if (out_data.dropped_some !== exp_res.dropped_some)
          report_mismatch($sformatf("dropped_some %0b exp %0b",
                                    out_data.dropped_some, exp_res.dropped_some));
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("per_class_box_suppression_core test failed");
      $finish;
    end
  end

  // Build a random box; clustered boxes make overlaps likely.
  function automatic pcbs_in_t random_box(input bit last, input bit clustered);
    pcbs_in_t b;
    b.box_left   = 16'($urandom());
    b.box_top    = 16'($urandom());
    b.box_width  = 16'($urandom());
    b.box_height = 16'($urandom());
    b.score      = 16'($urandom());
    b.class_id   = 8'($urandom());
    if (clustered) begin
      b.box_left   = 16'(1000 + $urandom_range(200));
      b.box_top    = 16'(2000 + $urandom_range(200));
      b.box_width  = 16'(300 + $urandom_range(200));
      b.box_height = 16'(300 + $urandom_range(200));
      b.class_id   = 8'($urandom_range(2));
      if ($urandom_range(9) == 0) b.score = 16'd500;
    end
    b.frame_end = last;
    return b;
  endfunction

  // Queue one random frame of the given size.
  task automatic queue_frame(input int count);
    bit clustered;
    clustered = ($urandom_range(3) != 0);
    for (int i = 0; i < count; i++)
      pending_boxes.push_back(random_box(i == count - 1, clustered));
    frames_sent++;
  endtask

  // Wait until every queued box is sent and every kept box has arrived.
  task automatic drain_all();
    while (pending_boxes.size() > 0 || in_valid || expected_kept.size() > 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [15:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    threshold = value;
  endtask

  // Stimulus sequence.
  initial begin
    pcbs_in_t b;
    logic [15:0] thr_set[4];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    error_count = 0;
    boxes_sent = 0;
    kept_seen = 0;
    frames_sent = 0;
    cycle_count = 0;
    frame_overflow = 1'b0;
    threshold = THR_RESET;
    idle_phase = PH_NONE;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: two single box frames, one with all-ones and one with all-zeros fields.
    b = '1;
    pending_boxes.push_back(b);
    b = '0;
    b.frame_end = 1'b1;
    pending_boxes.push_back(b);
    // Nearly identical boxes, same class, equal score: the first arrival survives.
    b = '{16'd100, 16'd100, 16'd50, 16'd50, 16'd900, 8'd3, 1'b0};
    pending_boxes.push_back(b);
    b.box_left = 16'd101;
    pending_boxes.push_back(b);
    // Same geometry but another class is never suppressed.
    b.class_id = 8'd4;
    pending_boxes.push_back(b);
    // Degenerate boxes: zero width and zero height.
    b = '{16'd100, 16'd100, 16'd0, 16'd50, 16'd1000, 8'd3, 1'b0};
    pending_boxes.push_back(b);
    b = '{16'd100, 16'd100, 16'd50, 16'd0, 16'd1000, 8'd3, 1'b0};
    pending_boxes.push_back(b);
    // Far edges that reach past 16 bits, then frame end.
    b = '{16'hFFF0, 16'hFFF0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0};
    pending_boxes.push_back(b);
    b = '{16'hFFF8, 16'hFFF8, 16'hFFFF, 16'hFFFF, 16'h0000, 8'hFF, 1'b1};
    pending_boxes.push_back(b);
    drain_all();

    // Over capacity frame, its frame end among the dropped boxes.
    queue_frame(CAPACITY + 3);
    drain_all();

    // Random frames across thresholds and idle phases.
    thr_set = '{16'd0, 16'd65535, 16'd16384, THR_RESET};
    for (int p = 0; p < 4; p++) begin
      write_threshold(thr_set[p]);
      idle_phase = idle_phase_e'(p);
      repeat (4) queue_frame(($urandom_range(4) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 8));
      drain_all();
    end
    idle_phase = PH_NONE;
    write_threshold(16'($urandom()));
    repeat (3) queue_frame($urandom_range(1, 6));
    drain_all();

    $display("Covered %0d boxes in %0d random frames, %0d kept boxes checked.",
             boxes_sent, frames_sent, kept_seen);
    $display("Thresholds from 0 to 65535, with sender and receiver idling.");
    if (error_count == 0 && expected_kept.size() == 0) begin
      $display("per_class_box_suppression_core test passed");
    end else begin
      $display("per_class_box_suppression_core test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/pcbs_pkg.sv
hdl/pcbs_sort_cell.sv
hdl/pcbs_kept_cell.sv
hdl/pcbs_overlap.sv
hdl/per_class_box_suppression_core.sv
bench/per_class_box_suppression_core_tb.sv
